### hdl/hmsc_pkg.sv
// ----------------------------------------------------------------------------
// hmsc_pkg
// Shared widths, font table and glyph helpers for the HH:MM:SS clock.
// ----------------------------------------------------------------------------
package hmsc_pkg;

    localparam int PRESCALE_BITS = 26;
    localparam int TPH_W         = 26;
    localparam int CMP_W         = (PRESCALE_BITS > TPH_W) ? PRESCALE_BITS : TPH_W;
    localparam int ROW_W         = 27;
    localparam int NUM_ROWS      = 5;
    localparam int HOUR_W        = 7;
    localparam int MIN_W         = 6;
    localparam int SEC_W         = 6;

    localparam logic [TPH_W-1:0] TPH_RESET = TPH_W'(25000000);

    localparam logic [SEC_W-1:0]  SEC_LAST  = SEC_W'(59);
    localparam logic [MIN_W-1:0]  MIN_LAST  = MIN_W'(59);
    localparam logic [HOUR_W-1:0] HOUR_LAST = HOUR_W'(99);

    localparam logic [19:0] FONT [10] = '{
        20'h75557, 20'h11111, 20'h71747, 20'h71717, 20'h55711,
        20'h74717, 20'h74757, 20'h71111, 20'h75757, 20'h75711
    };
    localparam logic [19:0] COLON_GLYPH = 20'h02020;

    typedef struct packed {
        logic [HOUR_W-1:0] hours;
        logic [MIN_W-1:0]  minutes;
        logic [SEC_W-1:0]  seconds;
        logic              colon;
    } time_t;

    typedef logic [NUM_ROWS-1:0][ROW_W-1:0] rows_t;

    function automatic logic [2:0] glyph_row(logic [19:0] pattern, int row);
        logic [19:0] shifted;
        shifted = pattern >> ((4 - row) * 4);
        return shifted[2:0];
    endfunction

    function automatic logic [2:0] digit_row(logic [3:0] value, int row);
        logic [2:0] bits;
        bits = 3'b000;
        if (value <= 4'd9)
        begin
            bits = glyph_row(FONT[value], row);
        end
        return bits;
    endfunction

    // tens digit of a 7-bit value, by reciprocal multiply
    function automatic logic [3:0] tens_of(logic [6:0] value);
        logic [14:0] prod;
        prod = 15'(value) * 15'd205;
        return prod[14:11];
    endfunction

    function automatic logic [3:0] units_of(logic [6:0] value);
        logic [6:0] diff;
        diff = value - 7'(tens_of(value)) * 7'd10;
        return diff[3:0];
    endfunction

endpackage

### hdl/hmsc_in_if.sv
// ----------------------------------------------------------------------------
// hmsc_in_if
// Input channel: one tick or one time load per item.
// ----------------------------------------------------------------------------
interface hmsc_in_if
    import hmsc_pkg::*;
;
    logic              valid;
    logic              ready;
    logic              mode;
    logic [HOUR_W-1:0] load_hours;
    logic [MIN_W-1:0]  load_minutes;
    logic [SEC_W-1:0]  load_seconds;

    modport source (
        output valid, mode, load_hours, load_minutes, load_seconds,
        input  ready
    );
    modport sink (
        input  valid, mode, load_hours, load_minutes, load_seconds,
        output ready
    );
endinterface

### hdl/hmsc_out_if.sv
// ----------------------------------------------------------------------------
// hmsc_out_if
// Result channel: dot-matrix rows, current time and flags.
// ----------------------------------------------------------------------------
interface hmsc_out_if
    import hmsc_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [ROW_W-1:0]  row_top;
    logic [ROW_W-1:0]  row_second;
    logic [ROW_W-1:0]  row_middle;
    logic [ROW_W-1:0]  row_fourth;
    logic [ROW_W-1:0]  row_bottom;
    logic [HOUR_W-1:0] hours_now;
    logic [MIN_W-1:0]  minutes_now;
    logic [SEC_W-1:0]  seconds_now;
    logic              colon_visible;
    logic              expired;

    modport source (
        output valid, row_top, row_second, row_middle, row_fourth, row_bottom,
               hours_now, minutes_now, seconds_now, colon_visible, expired,
        input  ready
    );
    modport sink (
        input  valid, row_top, row_second, row_middle, row_fourth, row_bottom,
               hours_now, minutes_now, seconds_now, colon_visible, expired,
        output ready
    );
endinterface

### hdl/hmsc_render.sv
// ----------------------------------------------------------------------------
// hmsc_render
// Draws HH:MM:SS as five 27-column rows in a 3x5 font.
// ----------------------------------------------------------------------------
module hmsc_render
    import hmsc_pkg::*;
(
    input  time_t tm,
    output rows_t rows
);

    logic [3:0] h_tens;
    logic [3:0] h_units;
    logic [3:0] m_tens;
    logic [3:0] m_units;
    logic [3:0] s_tens;
    logic [3:0] s_units;

    assign h_tens  = tens_of(tm.hours);
    assign h_units = units_of(tm.hours);
    assign m_tens  = tens_of(7'(tm.minutes));
    assign m_units = units_of(7'(tm.minutes));
    assign s_tens  = tens_of(7'(tm.seconds));
    assign s_units = units_of(7'(tm.seconds));

    for (genvar r = 0; r < NUM_ROWS; r++)
    begin : g_row
        logic [2:0] colon_bits;
        logic       colon_dot;

        assign colon_bits = glyph_row(COLON_GLYPH, r);
        assign colon_dot  = tm.colon & colon_bits[1];

        assign rows[r] = {
            digit_row(h_tens, r),  1'b0,
            digit_row(h_units, r), 1'b0,
            colon_dot,             1'b0,
            digit_row(m_tens, r),  1'b0,
            digit_row(m_units, r), 1'b0,
            colon_dot,             1'b0,
            digit_row(s_tens, r),  1'b0,
            digit_row(s_units, r)
        };
    end

endmodule

### hdl/hms_clock_with_dot_matrix_rows_core.sv
// ----------------------------------------------------------------------------
// hms_clock_with_dot_matrix_rows_core
// HH:MM:SS clock with a half-second prescaler and a 3x5 dot-matrix image.
// ----------------------------------------------------------------------------
// Takes one item per clock cycle: a tick or a time load. The prescaler, colon,
// time counters and expired flag update at the edge the item is accepted, and
// the result for that item is shown on the next cycle from those registers;
// the pixel rows are drawn from the held time, so a stalled result stays put.
// Input is taken whenever the result slot is empty or being taken, giving one
// item per cycle while results are taken. ticks_per_half_second may be
// written only while the block is idle; zero behaves as one.
// ----------------------------------------------------------------------------
module hms_clock_with_dot_matrix_rows_core
    import hmsc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_wr_en,
    input  logic [TPH_W-1:0] cfg_wr_data,
    hmsc_in_if.sink          in_ch,
    hmsc_out_if.source       out_ch
);

    logic [TPH_W-1:0]         tph_reg;
    logic [PRESCALE_BITS-1:0] tick_count_reg;
    logic [PRESCALE_BITS-1:0] tick_count_next;
    logic                     half_phase_reg;
    logic                     half_phase_next;
    logic [HOUR_W-1:0]        hour_count_reg;
    logic [HOUR_W-1:0]        hour_count_next;
    logic [MIN_W-1:0]         minute_count_reg;
    logic [MIN_W-1:0]         minute_count_next;
    logic [SEC_W-1:0]         second_count_reg;
    logic [SEC_W-1:0]         second_count_next;
    logic                     colon_flag_reg;
    logic                     colon_flag_next;
    logic                     frozen_flag_reg;
    logic                     frozen_flag_next;
    logic                     out_valid_reg;
    logic                     out_valid_next;

    logic                     accept;
    logic [PRESCALE_BITS-1:0] tick_inc;
    logic                     half_event;
    time_t                    tm;
    rows_t                    rows;

    assign in_ch.ready = !out_valid_reg || out_ch.ready;
    assign accept      = in_ch.valid && in_ch.ready;

    assign tick_inc   = tick_count_reg + PRESCALE_BITS'(1);
    assign half_event = (tph_reg == '0) || (tick_inc == '0)
                        || (CMP_W'(tick_inc) >= CMP_W'(tph_reg));

    always_comb
    begin
        tick_count_next   = tick_count_reg;
        half_phase_next   = half_phase_reg;
        hour_count_next   = hour_count_reg;
        minute_count_next = minute_count_reg;
        second_count_next = second_count_reg;
        colon_flag_next   = colon_flag_reg;
        frozen_flag_next  = frozen_flag_reg;
        out_valid_next    = out_valid_reg && !out_ch.ready;

        if (accept)
        begin
            out_valid_next = 1'b1;
            if (in_ch.mode)
            begin
                hour_count_next   = in_ch.load_hours;
                minute_count_next = in_ch.load_minutes;
                second_count_next = in_ch.load_seconds;
                tick_count_next   = '0;
                half_phase_next   = 1'b0;
                frozen_flag_next  = 1'b0;
            end
            else if (!frozen_flag_reg)
            begin
                if (!half_event)
                begin
                    tick_count_next = tick_inc;
                end
                else
                begin
                    tick_count_next = '0;
                    half_phase_next = !half_phase_reg;
                    colon_flag_next = !colon_flag_reg;
                    if (half_phase_reg)
                    begin
                        if (second_count_reg < SEC_LAST)
                        begin
                            second_count_next = second_count_reg + SEC_W'(1);
                        end
                        else if (minute_count_reg < MIN_LAST)
                        begin
                            second_count_next = '0;
                            minute_count_next = minute_count_reg + MIN_W'(1);
                        end
                        else if (hour_count_reg < HOUR_LAST)
                        begin
                            second_count_next = '0;
                            minute_count_next = '0;
                            hour_count_next   = hour_count_reg + HOUR_W'(1);
                        end
                        else
                        begin
                            // freeze: time, phase and colon hold
                            frozen_flag_next = 1'b1;
                            half_phase_next  = half_phase_reg;
                            colon_flag_next  = colon_flag_reg;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tph_reg          <= TPH_RESET;
            tick_count_reg   <= '0;
            half_phase_reg   <= 1'b0;
            hour_count_reg   <= '0;
            minute_count_reg <= '0;
            second_count_reg <= '0;
            colon_flag_reg   <= 1'b1;
            frozen_flag_reg  <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                tph_reg <= cfg_wr_data;
            end
            tick_count_reg   <= tick_count_next;
            half_phase_reg   <= half_phase_next;
            hour_count_reg   <= hour_count_next;
            minute_count_reg <= minute_count_next;
            second_count_reg <= second_count_next;
            colon_flag_reg   <= colon_flag_next;
            frozen_flag_reg  <= frozen_flag_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    assign tm.hours   = hour_count_reg;
    assign tm.minutes = minute_count_reg;
    assign tm.seconds = second_count_reg;
    assign tm.colon   = colon_flag_reg;

    hmsc_render u_render (
        .tm   (tm),
        .rows (rows)
    );

    assign out_ch.valid         = out_valid_reg;
    assign out_ch.row_top       = rows[0];
    assign out_ch.row_second    = rows[1];
    assign out_ch.row_middle    = rows[2];
    assign out_ch.row_fourth    = rows[3];
    assign out_ch.row_bottom    = rows[4];
    assign out_ch.hours_now     = hour_count_reg;
    assign out_ch.minutes_now   = minute_count_reg;
    assign out_ch.seconds_now   = second_count_reg;
    assign out_ch.colon_visible = colon_flag_reg;
    assign out_ch.expired       = frozen_flag_reg;

    a_accept_gives_result: assert property (
        @(posedge clk) disable iff (!rst_n)
        accept |=> out_valid_reg
    ) else $error("accepted item produced no result");

    a_load_clears: assert property (
        @(posedge clk) disable iff (!rst_n)
        (accept && in_ch.mode) |=>
            (!frozen_flag_reg && !half_phase_reg && tick_count_reg == '0)
    ) else $error("load did not clear prescaler and expiry");

    a_frozen_holds: assert property (
        @(posedge clk) disable iff (!rst_n)
        (accept && !in_ch.mode && frozen_flag_reg) |=>
            ($stable(hour_count_reg) && $stable(minute_count_reg)
             && $stable(second_count_reg) && $stable(colon_flag_reg))
    ) else $error("time moved while expired");

    a_colon_follows_phase: assert property (
        @(posedge clk) disable iff (!rst_n)
        (accept && !in_ch.mode) |=>
            ((colon_flag_reg ^ $past(colon_flag_reg))
             == (half_phase_reg ^ $past(half_phase_reg)))
    ) else $error("colon toggle out of step with half-second phase");

endmodule

### bench/tb_hms_clock_with_dot_matrix_rows_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_hms_clock_with_dot_matrix_rows_core
// Self-checking bench for the HH:MM:SS clock with dot-matrix rows.
// ----------------------------------------------------------------------------
// Ticks and time loads are driven through the input channel while the result
// channel is stalled at random. Every accepted item is run through a local
// model of the prescaler, the time counters and the 3x5 font, and each
// result is compared field by field with the oldest predicted frame. Named
// tests cover the reset state, the divisor extremes, expiry and freezing,
// out-of-range counts and a long stretch of random traffic under several
// divisor settings.
// ----------------------------------------------------------------------------
module tb_hms_clock_with_dot_matrix_rows_core
    import hmsc_pkg::*;
;

    localparam logic MODE_TICK    = 1'b0;
    localparam logic MODE_LOAD    = 1'b1;
    localparam int   LIMIT_CYCLES = 200000;
    localparam logic [TPH_W-1:0] TPH_MAX = {TPH_W{1'b1}};

    typedef struct {
        rows_t             rows;
        logic [HOUR_W-1:0] hours;
        logic [MIN_W-1:0]  minutes;
        logic [SEC_W-1:0]  seconds;
        logic              colon;
        logic              expired_flag;
    } frame_t;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_wr_en;
    logic [TPH_W-1:0] cfg_wr_data;

    hmsc_in_if  in_ch();
    hmsc_out_if out_ch();

    hms_clock_with_dot_matrix_rows_core dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_ch       (in_ch),
        .out_ch      (out_ch)
    );

    always #5 clk = ~clk;

    // local copy of the clock state
    logic [TPH_W-1:0]         divisor;
    logic [PRESCALE_BITS-1:0] tick_cnt;
    logic                     half_ph;
    logic [HOUR_W-1:0]        hrs;
    logic [MIN_W-1:0]         mins;
    logic [SEC_W-1:0]         secs;
    logic                     colon_on;
    logic                     frozen;

    frame_t expected_frames[$];
    frame_t frame_due;

    bit steady_flow = 1'b0;
    int fail_count = 0;
    int items_sent = 0;
    int loads_sent = 0;
    int results_checked = 0;
    int half_steps = 0;
    int expiries = 0;
    int divisor_writes = 0;
    int cycle_count = 0;

    function automatic rows_t draw_time(logic [HOUR_W-1:0] h, logic [MIN_W-1:0] m,
                                        logic [SEC_W-1:0] s, logic show_colon);
        rows_t       img;
        int unsigned digit [6];
        int unsigned shift_at [6];
        logic [19:0] pattern;
        digit[0] = h / 10;
        digit[1] = h % 10;
        digit[2] = m / 10;
        digit[3] = m % 10;
        digit[4] = s / 10;
        digit[5] = s % 10;
        shift_at = '{24, 20, 14, 10, 4, 0};
        for (int r = 0; r < NUM_ROWS; r++)
        begin
            img[r] = '0;
            for (int i = 0; i < 6; i++)
            begin
                if (digit[i] <= 9)
                begin
                    pattern = FONT[digit[i]] >> ((4 - r) * 4);
                    img[r] = img[r] | (ROW_W'(pattern[2:0]) << shift_at[i]);
                end
            end
            if (show_colon)
            begin
                pattern = COLON_GLYPH >> ((4 - r) * 4);
                img[r] = img[r] | (ROW_W'(pattern[2:0]) << 7)
                                | (ROW_W'(pattern[2:0]) << 17);
            end
        end
        return img;
    endfunction

    function automatic frame_t clock_predict(logic md, logic [HOUR_W-1:0] h,
                                             logic [MIN_W-1:0] m, logic [SEC_W-1:0] s);
        frame_t                   f;
        logic [PRESCALE_BITS-1:0] next_count;
        logic                     hit_limit;
        hit_limit = 1'b0;
        if (md == MODE_LOAD)
        begin
            hrs      = h;
            mins     = m;
            secs     = s;
            tick_cnt = '0;
            half_ph  = 1'b0;
            frozen   = 1'b0;
        end
        else if (!frozen)
        begin
            next_count = tick_cnt + 1'b1;
            if (divisor == '0 || next_count == '0 ||
                CMP_W'(next_count) >= CMP_W'(divisor))
            begin
                tick_cnt = '0;
                half_steps++;
                if (half_ph)
                begin
                    if (secs >= SEC_LAST)
                    begin
                        if (mins >= MIN_LAST)
                        begin
                            if (hrs >= HOUR_LAST)
                            begin
                                hit_limit = 1'b1;
                            end
                            else
                            begin
                                hrs  = hrs + 1'b1;
                                mins = '0;
                                secs = '0;
                            end
                        end
                        else
                        begin
                            mins = mins + 1'b1;
                            secs = '0;
                        end
                    end
                    else
                    begin
                        secs = secs + 1'b1;
                    end
                end
                if (hit_limit)
                begin
                    frozen = 1'b1;
                    expiries++;
                end
                else
                begin
                    half_ph  = ~half_ph;
                    colon_on = ~colon_on;
                end
            end
            else
            begin
                tick_cnt = next_count;
            end
        end
        f.rows         = draw_time(hrs, mins, secs, colon_on);
        f.hours        = hrs;
        f.minutes      = mins;
        f.seconds      = secs;
        f.colon        = colon_on;
        f.expired_flag = frozen;
        return f;
    endfunction

    task automatic send_item(input logic md, input logic [HOUR_W-1:0] h,
                             input logic [MIN_W-1:0] m, input logic [SEC_W-1:0] s);
        while (!steady_flow && $urandom_range(0, 99) < 22)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.mode         <= md;
        in_ch.load_hours   <= h;
        in_ch.load_minutes <= m;
        in_ch.load_seconds <= s;
        @(posedge clk);
        while (!in_ch.ready)
        begin
            @(posedge clk);
        end
        expected_frames.push_back(clock_predict(md, h, m, s));
        items_sent++;
        if (md == MODE_LOAD)
        begin
            loads_sent++;
        end
    endtask

    task automatic send_tick();
        send_item(MODE_TICK, HOUR_W'($urandom), MIN_W'($urandom), SEC_W'($urandom));
    endtask

    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        while (expected_frames.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (2) @(posedge clk);
    endtask

    task automatic write_divisor(input logic [TPH_W-1:0] value);
        wait_drained();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= TPH_W'($urandom);
        divisor = value;
        divisor_writes++;
    endtask

    task automatic compare_field(input string name, input logic [ROW_W-1:0] want,
                                 input logic [ROW_W-1:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk)
    begin
        out_ch.ready <= steady_flow ? 1'b1 : ($urandom_range(0, 99) >= 22);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (expected_frames.size() == 0)
            begin
                $error("result arrived with no frame expected");
                fail_count++;
            end
            else
            begin
                frame_due = expected_frames.pop_front();
                compare_field("row_top", frame_due.rows[0], out_ch.row_top);
                compare_field("row_second", frame_due.rows[1], out_ch.row_second);
                compare_field("row_middle", frame_due.rows[2], out_ch.row_middle);
                compare_field("row_fourth", frame_due.rows[3], out_ch.row_fourth);
                compare_field("row_bottom", frame_due.rows[4], out_ch.row_bottom);
                compare_field("hours_now", frame_due.hours, out_ch.hours_now);
                compare_field("minutes_now", frame_due.minutes, out_ch.minutes_now);
                compare_field("seconds_now", frame_due.seconds, out_ch.seconds_now);
                compare_field("colon_visible", frame_due.colon, out_ch.colon_visible);
                compare_field("expired", frame_due.expired_flag, out_ch.expired);
                results_checked++;
            end
        end
    end

    initial
    begin
        while (cycle_count < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    task automatic test_reset_defaults();
        repeat (3) send_tick();
    endtask

    task automatic test_divisor_extremes();
        write_divisor('0);
        repeat (4) send_tick();
        write_divisor(TPH_MAX);
        repeat (2) send_tick();
        write_divisor(TPH_W'(1));
        repeat (2) send_tick();
    endtask

    task automatic test_expiry_and_freeze();
        send_item(MODE_LOAD, 7'd99, 6'd59, 6'd59);
        repeat (4) send_tick();
        send_item(MODE_LOAD, 7'd0, 6'd0, 6'd0);
        send_item(MODE_LOAD, 7'd9, 6'd59, 6'd59);
        repeat (2) send_tick();
    endtask

    task automatic test_out_of_range_counts();
        send_item(MODE_LOAD, 7'd127, 6'd63, 6'd63);
        repeat (3) send_tick();
        send_item(MODE_LOAD, 7'd100, 6'd60, 6'd61);
        repeat (2) send_tick();
    endtask

    task automatic test_random_traffic();
        logic [TPH_W-1:0] value;
        int               count;
        int unsigned      roll;
        for (int p = 0; p < 7; p++)
        begin
            count = 95;
            case (p)
                0: value = TPH_W'(1);
                1: value = TPH_W'(2);
                2: value = '0;
                3: value = TPH_W'(3);
                4: value = TPH_W'($urandom_range(4, 9));
                5:
                begin
                    value = TPH_W'($urandom_range(1, 67108863));
                    count = 40;
                end
                default: value = TPH_W'(1);
            endcase
            write_divisor(value);
            steady_flow = (p == 3);
            for (int n = 0; n < count; n++)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 8)
                begin
                    send_item(MODE_LOAD, HOUR_W'($urandom_range(0, 99)),
                              MIN_W'($urandom_range(0, 59)), SEC_W'($urandom_range(0, 59)));
                end
                else if (roll < 11)
                begin
                    send_item(MODE_LOAD, HOUR_W'($urandom_range(97, 99)), MIN_LAST,
                              SEC_W'($urandom_range(56, 59)));
                end
                else if (roll < 12)
                begin
                    send_item(MODE_LOAD, HOUR_W'($urandom), MIN_W'($urandom),
                              SEC_W'($urandom));
                end
                else
                begin
                    send_tick();
                end
            end
            steady_flow = 1'b0;
        end
    endtask

    initial
    begin
        rst_n              = 1'b0;
        cfg_wr_en          = 1'b0;
        cfg_wr_data        = '0;
        in_ch.valid        = 1'b0;
        in_ch.mode         = MODE_TICK;
        in_ch.load_hours   = '0;
        in_ch.load_minutes = '0;
        in_ch.load_seconds = '0;
        out_ch.ready       = 1'b0;
        divisor  = TPH_RESET;
        tick_cnt = '0;
        half_ph  = 1'b0;
        hrs      = '0;
        mins     = '0;
        secs     = '0;
        colon_on = 1'b1;
        frozen   = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_divisor_extremes();
        test_expiry_and_freeze();
        test_out_of_range_counts();
        test_random_traffic();

        wait_drained();
        repeat (5) @(posedge clk);
        $display("Ran %0d items (%0d time loads) across %0d divisor writes; %0d results checked.",
                 items_sent, loads_sent, divisor_writes, results_checked);
        $display("Model saw %0d half-second steps and %0d expiries.", half_steps, expiries);
        if (fail_count == 0 && expected_frames.size() == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

### hms_clock_with_dot_matrix_rows_core.f
hdl/hmsc_pkg.sv
hdl/hmsc_in_if.sv
hdl/hmsc_out_if.sv
hdl/hmsc_render.sv
hdl/hms_clock_with_dot_matrix_rows_core.sv
bench/tb_hms_clock_with_dot_matrix_rows_core.sv
